// File: rtl/bpfa_pkg.sv
package bpfa_pkg;

  // Geometry of the bitmap
  localparam int PAGES     = 4096;
  localparam int WORD_BITS = 32;
  localparam int NWORDS    = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int PG_W      = $clog2(PAGES);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int AW        = $clog2(NWORDS);
  localparam int LIM_W     = $clog2(PAGES + 1);
  localparam int LIM_HI_W  = LIM_W - BIT_W;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_MARK  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOCHANGE = 2'd2;

  localparam logic [LIM_W-1:0] PAGES_L = LIM_W'(PAGES);

  typedef logic [WORD_BITS-1:0] word_t;

endpackage

// File: rtl/bpfa_req_if.sv
interface bpfa_req_if import bpfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PG_W-1:0]   page_number;

  modport source (output valid, func, page_number, input ready);
  modport sink   (input valid, func, page_number, output ready);
endinterface

// File: rtl/bpfa_rsp_if.sv
interface bpfa_rsp_if import bpfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PG_W-1:0]     alloc_page;
  logic                page_free;
  logic [LIM_W-1:0]    used_count;
  logic [LIM_W-1:0]    free_count;

  modport source (output valid, status, alloc_page, page_free, used_count, free_count,
                  input ready);
  modport sink   (input valid, status, alloc_page, page_free, used_count, free_count,
                  output ready);
endinterface

// File: rtl/bpfa_ram.sv
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bitmap_page_frame_allocator.sv
// First-fit page frame allocator over a used-bit bitmap held in one RAM
// (NWORDS words of WORD_BITS bits, one bit per page, 1 = used). Free, mark
// used and query do one RAM read, then write back the changed word; query only
// reads. Alloc reads the bitmap one word per cycle from word 0 and stops at
// the first word with a free page below the limit, or at the last word in
// range with none free; the single read port of the bitmap RAM sets
// that rate. One item is in flight at a time; the result sits in an output
// register, so the next item is taken while it waits. After reset every
// page reads as used without a clearing pass: a per-word valid flag makes
// unwritten words read as all ones. The user must write the page limit through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LIM_W-1:0]  cfg_wdata,
  bpfa_req_if.sink          in_chan,
  bpfa_rsp_if.source        out_chan
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state_r, state_nxt;
  logic [LIM_W-1:0]    total_r;
  logic [LIM_W-1:0]    used_total_r, used_total_nxt;
  logic [NWORDS-1:0]   wvalid_r;
  logic                vld_rd_r;
  logic [AW-1:0]       waddr_r, waddr_nxt;
  logic [FUNC_W-1:0]   func_r;
  logic [PG_W-1:0]     pg_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [PG_W-1:0]     grant_r;
  logic                pfree_r;
  logic [LIM_W-1:0]    usedc_r;
  logic [LIM_W-1:0]    freec_r;

  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  word_t               ram_rdata;
  logic                ram_we;
  word_t               ram_wdata;

  logic [LIM_W-1:0]    lim;
  logic [LIM_HI_W-1:0] lim_hi;
  word_t               word_eff;
  word_t               elig;
  word_t               free_vec;
  logic                found;
  logic [BIT_W-1:0]    fidx;
  logic                last_word;
  logic                bit_sel;
  logic                inr;
  logic                finish;
  logic                out_ld;
  logic                in_acc;
  logic [STATUS_W-1:0] status_c;
  logic [PG_W-1:0]     grant_c;
  logic                pfree_c;
  logic                modify;
  logic                inc;
  logic                dec;

  // Effective limit and current word view
  always_comb begin
    lim      = (total_r > PAGES_L) ? PAGES_L : total_r;
    lim_hi   = lim[LIM_W-1:BIT_W];
    word_eff = vld_rd_r ? ram_rdata : '1;
    for (int b = 0; b < WORD_BITS; b++) begin
      elig[b] = ({1'b0, waddr_r} < lim_hi) ||
                (({1'b0, waddr_r} == lim_hi) && (BIT_W'(b) < lim[BIT_W-1:0]));
    end
    free_vec = ~word_eff & elig;
    found    = |free_vec;
    fidx     = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        fidx = BIT_W'(b);
      end
    end
    last_word = ({1'b0, waddr_r} >= lim_hi) || (waddr_r == AW'(NWORDS - 1));
    bit_sel   = word_eff[pg_r[BIT_W-1:0]];
    inr       = ({1'b0, pg_r} < lim);
  end

  // Operation decode for the word in hand
  always_comb begin
    finish    = 1'b0;
    status_c  = ST_DONE;
    grant_c   = '0;
    pfree_c   = 1'b0;
    modify    = 1'b0;
    inc       = 1'b0;
    dec       = 1'b0;
    ram_wdata = word_eff;
    case (func_r)
      FN_ALLOC: begin
        if (found) begin
          finish    = 1'b1;
          modify    = 1'b1;
          inc       = 1'b1;
          grant_c   = {waddr_r, fidx};
          ram_wdata = word_eff | (word_t'(1) << fidx);
        end else if (last_word) begin
          finish   = 1'b1;
          status_c = ST_NOFREE;
        end
      end
      FN_FREE: begin
        finish = 1'b1;
        if (inr && bit_sel) begin
          modify    = 1'b1;
          dec       = 1'b1;
          ram_wdata = word_eff & ~(word_t'(1) << pg_r[BIT_W-1:0]);
        end else begin
          status_c = ST_NOCHANGE;
        end
      end
      FN_MARK: begin
        finish = 1'b1;
        if (inr && !bit_sel) begin
          modify    = 1'b1;
          inc       = 1'b1;
          ram_wdata = word_eff | (word_t'(1) << pg_r[BIT_W-1:0]);
        end else begin
          status_c = ST_NOCHANGE;
        end
      end
      FN_QUERY: begin
        finish = 1'b1;
        if (inr) begin
          pfree_c = !bit_sel;
        end else begin
          status_c = ST_NOCHANGE;
        end
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  // Handshakes, RAM control and sequencing
  always_comb begin
    in_acc    = in_chan.valid && in_chan.ready;
    out_ld    = (state_r == S_SCAN) && finish && (!out_valid_r || out_chan.ready);
    ram_we    = out_ld && modify;
    ram_re    = 1'b0;
    ram_raddr = waddr_r;
    waddr_nxt = waddr_r;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ram_re    = 1'b1;
          ram_raddr = (in_chan.func == FN_ALLOC) ? '0
                                                 : in_chan.page_number[PG_W-1:BIT_W];
          waddr_nxt = ram_raddr;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!finish) begin
          ram_re    = 1'b1;
          ram_raddr = waddr_r + AW'(1);
          waddr_nxt = ram_raddr;
        end else if (out_ld) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    used_total_nxt = used_total_r;
    if (out_ld && inc && (used_total_r < PAGES_L)) begin
      used_total_nxt = used_total_r + LIM_W'(1);
    end else if (out_ld && dec && (used_total_r != '0)) begin
      used_total_nxt = used_total_r - LIM_W'(1);
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);

  bpfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NWORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= PAGES_L;
      used_total_r <= PAGES_L;
      wvalid_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_total_r <= used_total_nxt;
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
      if (ram_we) begin
        wvalid_r[waddr_r] <= 1'b1;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    waddr_r <= waddr_nxt;
    if (ram_re) begin
      vld_rd_r <= wvalid_r[ram_raddr];
    end
    if (in_acc) begin
      func_r <= in_chan.func;
      pg_r   <= in_chan.page_number;
    end
    if (out_ld) begin
      status_r <= status_c;
      grant_r  <= grant_c;
      pfree_r  <= pfree_c;
      usedc_r  <= used_total_nxt;
      freec_r  <= (lim > used_total_nxt) ? (lim - used_total_nxt) : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = status_r;
  assign out_chan.alloc_page = grant_r;
  assign out_chan.page_free  = pfree_r;
  assign out_chan.used_count = usedc_r;
  assign out_chan.free_count = freec_r;

  // Checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_total_r <= PAGES_L)
    else $error("used page count above page total");

  a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_NOFREE) |-> (grant_r == '0))
    else $error("failed alloc reports a page");

  a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (freec_r == '0) || ((usedc_r + freec_r) == lim))
    else $error("used and free counts disagree with limit");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("bitmap written with no item in flight");

endmodule
